>>> sv/plm_pkg.sv
// ----------------------------------------------------------------------------
// Piecewise-linear limit mask package
// Field widths, request codes, register indexes and the no-limit values that
// the top level and the interpolation unit share.
// ----------------------------------------------------------------------------
package plm_pkg;

    localparam int REQ_W     = 2;
    localparam int SLOT_W    = 4;
    localparam int FIELD_X_W = 14;
    localparam int Y_W       = 15;
    localparam int COUNT_W   = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [REQ_W-1:0] REQ_UPPER = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOWER = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_COUNT = 1'b1;

    localparam logic [Y_W-1:0] NO_UPPER = 15'h4000;
    localparam logic [Y_W-1:0] NO_LOWER = 15'h0000;

endpackage

>>> sv/plm_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module plm_ram #(
    parameter int WIDTH = 29,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/plm_interp.sv
// ----------------------------------------------------------------------------
// Interpolation unit
// Computes y1 + floor((y2 - y1) * (i - x1) / (x2 - x1)) with a multiply
// state and a restoring divider that yields one quotient bit per cycle.
// ----------------------------------------------------------------------------
module plm_interp #(
    parameter int XW = 14
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [XW-1:0]             i_x1,
    input  logic [XW-1:0]             i_x2,
    input  logic [XW-1:0]             i_sample,
    input  logic [plm_pkg::Y_W-1:0]   i_y1,
    input  logic [plm_pkg::Y_W-1:0]   i_y2,
    output logic                      o_done,
    output logic [plm_pkg::Y_W-1:0]   o_result
);
    import plm_pkg::*;

    localparam int NW   = Y_W + XW;
    localparam int CNTW = $clog2(NW);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_FIX  = 2'd3;

    logic [1:0]      r_state, n_state;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic            r_done, n_done;
    logic            r_neg, n_neg;
    logic [Y_W-1:0]  r_mag, n_mag;
    logic [Y_W-1:0]  r_y1, n_y1;
    logic [XW-1:0]   r_dx, n_dx;
    logic [XW-1:0]   r_span, n_span;
    logic [NW-1:0]   r_num, n_num;
    logic [XW-1:0]   r_rem, n_rem;
    logic [Y_W-1:0]  r_res, n_res;

    logic [XW:0]     w_shift;
    logic [XW+1:0]   w_trial;
    logic [Y_W-1:0]  w_q;

    assign w_shift = {r_rem, r_num[NW-1]};
    assign w_trial = {1'b0, w_shift} - {2'b00, r_span};
    assign w_q     = r_num[Y_W-1:0];

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        n_neg   = r_neg;
        n_mag   = r_mag;
        n_y1    = r_y1;
        n_dx    = r_dx;
        n_span  = r_span;
        n_num   = r_num;
        n_rem   = r_rem;
        n_res   = r_res;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_neg   = i_y2 < i_y1;
                    n_mag   = (i_y2 < i_y1) ? (i_y1 - i_y2) : (i_y2 - i_y1);
                    n_y1    = i_y1;
                    n_dx    = i_sample - i_x1;
                    n_span  = i_x2 - i_x1;
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_num   = r_mag * r_dx;
                n_rem   = '0;
                n_cnt   = '0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (!w_trial[XW+1]) begin
                    n_rem = w_trial[XW-1:0];
                    n_num = {r_num[NW-2:0], 1'b1};
                end else begin
                    n_rem = w_shift[XW-1:0];
                    n_num = {r_num[NW-2:0], 1'b0};
                end
                n_cnt = r_cnt + CNTW'(1);
                if (r_cnt == CNTW'(NW - 1)) begin
                    n_state = ST_FIX;
                end
            end
            ST_FIX: begin
                if (r_neg) begin
                    n_res = r_y1 - w_q - Y_W'(|r_rem);
                end else begin
                    n_res = r_y1 + w_q;
                end
                n_done  = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_neg  <= n_neg;
        r_mag  <= n_mag;
        r_y1   <= n_y1;
        r_dx   <= n_dx;
        r_span <= n_span;
        r_num  <= n_num;
        r_rem  <= n_rem;
        r_res  <= n_res;
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

>>> sv/piecewise_linear_limit_mask_top.sv
// ----------------------------------------------------------------------------
// Piecewise-linear limit mask
// Loads are taken while the sequencer is idle and can follow back to back.
// A query reads one entry of each table per cycle up to the larger point
// count, then runs one serial divide per interpolated limit.
// Synchronous active-low reset clears the point counts and the sequencer.
// ----------------------------------------------------------------------------
module piecewise_linear_limit_mask_top #(
    parameter int MAX_POINTS = 16,
    parameter int INDEX_BITS = 14
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [plm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [plm_pkg::COUNT_W-1:0]       i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [plm_pkg::REQ_W-1:0]         i_req_type,
    input  logic [plm_pkg::SLOT_W-1:0]        i_point_slot,
    input  logic [plm_pkg::FIELD_X_W-1:0]     i_point_x,
    input  logic [plm_pkg::Y_W-1:0]           i_point_y,
    input  logic [plm_pkg::FIELD_X_W-1:0]     i_sample_index,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [plm_pkg::Y_W-1:0]           o_upper_limit,
    output logic [plm_pkg::Y_W-1:0]           o_lower_limit,
    output logic [plm_pkg::FIELD_X_W-1:0]     o_queried_index
);
    import plm_pkg::*;

    localparam int XW = INDEX_BITS;
    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int DW = Y_W + XW;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_WALK = 3'd1;
    localparam logic [2:0] ST_SEL  = 3'd2;
    localparam logic [2:0] ST_WAIT = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]                 r_state, n_state;
    logic [1:0][COUNT_W-1:0]    r_count, n_count;
    logic [CW-1:0]              r_addr, n_addr;
    logic                       r_dv, n_dv;
    logic [CW-1:0]              r_dk, n_dk;
    logic                       r_tsel, n_tsel;
    logic [XW-1:0]              r_idx, n_idx;
    logic [FIELD_X_W-1:0]       r_qidx, n_qidx;
    logic                       r_out_valid, n_out_valid;
    logic [Y_W-1:0]             r_out_up, n_out_up;
    logic [Y_W-1:0]             r_out_lo, n_out_lo;
    logic [FIELD_X_W-1:0]       r_out_qidx, n_out_qidx;

    logic [1:0]                 r_oor, n_oor;
    logic [1:0]                 r_eq_hit, n_eq_hit;
    logic [1:0]                 r_pr_hit, n_pr_hit;
    logic [1:0]                 r_in_hit, n_in_hit;
    logic [1:0][Y_W-1:0]        r_eq_y, n_eq_y;
    logic [1:0][Y_W-1:0]        r_pr_y, n_pr_y;
    logic [1:0][XW-1:0]         r_px, n_px;
    logic [1:0][Y_W-1:0]        r_py, n_py;
    logic [1:0][XW-1:0]         r_x1, n_x1;
    logic [1:0][XW-1:0]         r_x2, n_x2;
    logic [1:0][Y_W-1:0]        r_y1, n_y1;
    logic [1:0][Y_W-1:0]        r_y2, n_y2;
    logic [1:0][Y_W-1:0]        r_lim, n_lim;

    logic                       w_accept;
    logic [XW+FIELD_X_W-1:0]    w_px_ext;
    logic [XW+FIELD_X_W-1:0]    w_si_ext;
    logic [AW+SLOT_W-1:0]       w_slot_ext;
    logic                       w_slot_ok;
    logic [1:0]                 w_we;
    logic [DW-1:0]              w_wdata;
    logic [1:0][DW-1:0]         w_rdata;
    logic [CW+COUNT_W-1:0]      w_cnt_ext [2];
    logic [1:0][CW-1:0]         w_n;
    logic [CW-1:0]              w_nmax;
    logic                       w_start;
    logic                       w_done;
    logic [Y_W-1:0]             w_res;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_px_ext   = {{XW{1'b0}}, i_point_x};
    assign w_si_ext   = {{XW{1'b0}}, i_sample_index};
    assign w_slot_ext = {{AW{1'b0}}, i_point_slot};
    assign w_slot_ok  = 32'(i_point_slot) < 32'(MAX_POINTS);
    assign w_wdata    = {i_point_y, w_px_ext[XW-1:0]};
    assign w_we[0]    = w_accept && (i_req_type == REQ_UPPER) && w_slot_ok;
    assign w_we[1]    = w_accept && (i_req_type == REQ_LOWER) && w_slot_ok;

    for (genvar t = 0; t < 2; t++) begin : g_table
        assign w_cnt_ext[t] = {{CW{1'b0}}, r_count[t]};
        assign w_n[t] = (32'(r_count[t]) > 32'(MAX_POINTS)) ?
                        CW'(MAX_POINTS) : w_cnt_ext[t][CW-1:0];

        plm_ram #(
            .WIDTH (DW),
            .DEPTH (MAX_POINTS)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_we[t]),
            .i_waddr (w_slot_ext[AW-1:0]),
            .i_wdata (w_wdata),
            .i_raddr (r_addr[AW-1:0]),
            .o_rdata (w_rdata[t])
        );
    end

    assign w_nmax = (w_n[0] > w_n[1]) ? w_n[0] : w_n[1];

    assign w_start = (r_state == ST_SEL) && !((w_n[r_tsel] == '0) || r_oor[r_tsel])
                     && r_in_hit[r_tsel];

    plm_interp #(
        .XW (XW)
    ) u_interp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_x1     (r_x1[r_tsel]),
        .i_x2     (r_x2[r_tsel]),
        .i_sample (r_idx),
        .i_y1     (r_y1[r_tsel]),
        .i_y2     (r_y2[r_tsel]),
        .o_done   (w_done),
        .o_result (w_res)
    );

    always_comb begin
        logic [XW-1:0]  v_x;
        logic [Y_W-1:0] v_y;
        logic [Y_W-1:0] v_dflt;
        logic [Y_W-1:0] v_sel;

        n_state     = r_state;
        n_count     = r_count;
        n_addr      = r_addr;
        n_dv        = r_dv;
        n_dk        = r_dk;
        n_tsel      = r_tsel;
        n_idx       = r_idx;
        n_qidx      = r_qidx;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_up    = r_out_up;
        n_out_lo    = r_out_lo;
        n_out_qidx  = r_out_qidx;
        n_oor       = r_oor;
        n_eq_hit    = r_eq_hit;
        n_pr_hit    = r_pr_hit;
        n_in_hit    = r_in_hit;
        n_eq_y      = r_eq_y;
        n_pr_y      = r_pr_y;
        n_px        = r_px;
        n_py        = r_py;
        n_x1        = r_x1;
        n_x2        = r_x2;
        n_y1        = r_y1;
        n_y2        = r_y2;
        n_lim       = r_lim;
        v_dflt      = r_tsel ? NO_LOWER : NO_UPPER;
        if (r_pr_hit[r_tsel]) begin
            v_sel = r_pr_y[r_tsel];
        end else if (r_eq_hit[r_tsel]) begin
            v_sel = r_eq_y[r_tsel];
        end else begin
            v_sel = v_dflt;
        end

        if (i_cfg_we) begin
            if (i_cfg_index == CFG_UPPER_COUNT) begin
                n_count[0] = i_cfg_data;
            end else if (i_cfg_index == CFG_LOWER_COUNT) begin
                n_count[1] = i_cfg_data;
            end
        end

        for (int t = 0; t < 2; t++) begin
            v_x = w_rdata[t][XW-1:0];
            v_y = w_rdata[t][DW-1:XW];
            if ((r_state == ST_WALK) && r_dv && (r_dk < w_n[t])) begin
                if ((r_dk == '0) && (r_idx < v_x)) begin
                    n_oor[t] = 1'b1;
                end
                if (((r_dk + CW'(1)) == w_n[t]) && (r_idx > v_x)) begin
                    n_oor[t] = 1'b1;
                end
                if (v_x == r_idx) begin
                    n_eq_hit[t] = 1'b1;
                    n_eq_y[t]   = v_y;
                end
                if (r_dk != '0) begin
                    if ((r_px[t] == r_idx) && (v_x == r_idx)) begin
                        n_pr_hit[t] = 1'b1;
                        if (t == 0) begin
                            n_pr_y[t] = (r_py[t] <= v_y) ? r_py[t] : v_y;
                        end else begin
                            n_pr_y[t] = (r_py[t] >= v_y) ? r_py[t] : v_y;
                        end
                    end
                    if ((r_px[t] < r_idx) && (r_idx < v_x)) begin
                        n_in_hit[t] = 1'b1;
                        n_x1[t]     = r_px[t];
                        n_y1[t]     = r_py[t];
                        n_x2[t]     = v_x;
                        n_y2[t]     = v_y;
                    end
                end
                n_px[t] = v_x;
                n_py[t] = v_y;
            end
        end

        case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_req_type == REQ_QUERY)) begin
                    n_idx    = w_si_ext[XW-1:0];
                    n_qidx   = i_sample_index;
                    n_addr   = '0;
                    n_dv     = 1'b0;
                    n_tsel   = 1'b0;
                    n_oor    = '0;
                    n_eq_hit = '0;
                    n_pr_hit = '0;
                    n_in_hit = '0;
                    n_state  = ST_WALK;
                end
            end
            ST_WALK: begin
                if (r_addr < w_nmax) begin
                    n_addr = r_addr + CW'(1);
                    n_dv   = 1'b1;
                    n_dk   = r_addr;
                end else begin
                    n_dv = 1'b0;
                    if (!r_dv) begin
                        n_state = ST_SEL;
                    end
                end
            end
            ST_SEL: begin
                if (w_start) begin
                    n_state = ST_WAIT;
                end else begin
                    if ((w_n[r_tsel] == '0) || r_oor[r_tsel]) begin
                        n_lim[r_tsel] = v_dflt;
                    end else begin
                        n_lim[r_tsel] = v_sel;
                    end
                    if (r_tsel) begin
                        n_state = ST_DONE;
                    end else begin
                        n_tsel = 1'b1;
                    end
                end
            end
            ST_WAIT: begin
                if (w_done) begin
                    n_lim[r_tsel] = w_res;
                    if (r_tsel) begin
                        n_state = ST_DONE;
                    end else begin
                        n_tsel  = 1'b1;
                        n_state = ST_SEL;
                    end
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_up    = r_lim[0];
                    n_out_lo    = r_lim[1];
                    n_out_qidx  = r_qidx;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_addr      <= '0;
            r_dv        <= 1'b0;
            r_tsel      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_addr      <= n_addr;
            r_dv        <= n_dv;
            r_tsel      <= n_tsel;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dk       <= n_dk;
        r_idx      <= n_idx;
        r_qidx     <= n_qidx;
        r_out_up   <= n_out_up;
        r_out_lo   <= n_out_lo;
        r_out_qidx <= n_out_qidx;
        r_oor      <= n_oor;
        r_eq_hit   <= n_eq_hit;
        r_pr_hit   <= n_pr_hit;
        r_in_hit   <= n_in_hit;
        r_eq_y     <= n_eq_y;
        r_pr_y     <= n_pr_y;
        r_px       <= n_px;
        r_py       <= n_py;
        r_x1       <= n_x1;
        r_x2       <= n_x2;
        r_y1       <= n_y1;
        r_y2       <= n_y2;
        r_lim      <= n_lim;
    end

    assign o_in_ready      = (r_state == ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_upper_limit   = r_out_up;
    assign o_lower_limit   = r_out_lo;
    assign o_queried_index = r_out_qidx;

`ifndef ASSERT_OFF
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (r_state == ST_WAIT))
        else $error("interpolation result arrived outside the wait state");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_addr <= w_nmax))
        else $error("table walk ran past the point count");

    a_read_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv |-> (r_state == ST_WALK))
        else $error("table read data pending outside the walk");

    a_query_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_req_type == REQ_QUERY)) |=> (r_state == ST_WALK))
        else $error("query transaction did not start a table walk");
`endif

endmodule

>>> sim/piecewise_linear_limit_mask_top_tb.sv
// ----------------------------------------------------------------------------
// Piecewise-linear limit mask testbench
// Loads breakpoint tables and queries the upper and lower limits at chosen
// sample indexes. A scoreboard keeps its own copy of both tables and the
// point counts, predicts each query's limits and checks every result
// transaction in order, under random idling on both sides and a long
// receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module piecewise_linear_limit_mask_top_tb;

    import plm_pkg::*;

    localparam int MAX_PTS     = 16;
    localparam int LATENCY_MAX = 100;
    localparam int HOLD_CYCLES = 400;
    localparam int X_TOP       = 16383;
    localparam int Y_TOP       = 16384;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [Y_W-1:0]       upper_limit;
        logic [Y_W-1:0]       lower_limit;
        logic [FIELD_X_W-1:0] queried_index;
    } limits_t;

    class limit_scoreboard;
        logic [FIELD_X_W-1:0] up_x [MAX_PTS];
        logic [Y_W-1:0]       up_y [MAX_PTS];
        logic [FIELD_X_W-1:0] lo_x [MAX_PTS];
        logic [Y_W-1:0]       lo_y [MAX_PTS];
        logic [COUNT_W-1:0]   up_count;
        logic [COUNT_W-1:0]   lo_count;
        limits_t              expected_q [$];
        int                   errors;

        function new();
            up_count = '0;
            lo_count = '0;
            errors   = 0;
        endfunction

        function void set_count(input logic [CFG_IDX_W-1:0] idx,
                                input logic [COUNT_W-1:0] value);
            if (idx == CFG_UPPER_COUNT) begin
                up_count = value;
            end else begin
                lo_count = value;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function logic [Y_W-1:0] limit_on_line(input bit upper_line,
                                               input logic [FIELD_X_W-1:0] i);
            logic [FIELD_X_W-1:0] xs [MAX_PTS];
            logic [Y_W-1:0]       ys [MAX_PTS];
            logic [Y_W-1:0]       res;
            int                   n;
            longint               num;
            longint               span;
            longint               q;
            if (upper_line) begin
                xs  = up_x;
                ys  = up_y;
                n   = up_count;
                res = NO_UPPER;
            end else begin
                xs  = lo_x;
                ys  = lo_y;
                n   = lo_count;
                res = NO_LOWER;
            end
            if (n > MAX_PTS) begin
                n = MAX_PTS;
            end
            if (n == 0 || i < xs[0] || i > xs[n-1]) begin
                return res;
            end
            for (int k = 0; k < n; k++) begin
                if (xs[k] == i) begin
                    res = ys[k];
                end
            end
            for (int k = 0; k + 1 < n; k++) begin
                if (xs[k] == i && xs[k+1] == i) begin
                    if (upper_line) begin
                        res = (ys[k] <= ys[k+1]) ? ys[k] : ys[k+1];
                    end else begin
                        res = (ys[k] >= ys[k+1]) ? ys[k] : ys[k+1];
                    end
                end
            end
            for (int k = 0; k + 1 < n; k++) begin
                if (xs[k] < i && i < xs[k+1]) begin
                    num  = (longint'(ys[k+1]) - longint'(ys[k]))
                         * (longint'(i) - longint'(xs[k]));
                    span = longint'(xs[k+1]) - longint'(xs[k]);
                    q    = (num >= 0) ? num / span : -((-num + span - 1) / span);
                    res  = Y_W'(longint'(ys[k]) + q);
                end
            end
            return res;
        endfunction

        function void note_request(input logic [REQ_W-1:0] req,
                                   input logic [SLOT_W-1:0] slot,
                                   input logic [FIELD_X_W-1:0] px,
                                   input logic [Y_W-1:0] py,
                                   input logic [FIELD_X_W-1:0] si);
            limits_t lim;
            if (req == REQ_UPPER || req == REQ_LOWER) begin
                if (slot < MAX_PTS) begin
                    if (req == REQ_UPPER) begin
                        up_x[slot] = px;
                        up_y[slot] = py;
                    end else begin
                        lo_x[slot] = px;
                        lo_y[slot] = py;
                    end
                end
            end else if (req == REQ_QUERY) begin
                lim.upper_limit   = limit_on_line(1'b1, si);
                lim.lower_limit   = limit_on_line(1'b0, si);
                lim.queried_index = si;
                expected_q.push_back(lim);
            end
        endfunction

        function void check_result(input limits_t got);
            limits_t want;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("unexpected result: upper %0d lower %0d index %0d",
                             got.upper_limit, got.lower_limit, got.queried_index);
                end
                return;
            end
            want = expected_q.pop_front();
            if (got.upper_limit !== want.upper_limit
                    || got.lower_limit !== want.lower_limit
                    || got.queried_index !== want.queried_index) begin
                errors++;
                if (errors <= 10) begin
                    $display("limit error: upper %0d/%0d lower %0d/%0d index %0d/%0d",
                             want.upper_limit, got.upper_limit,
                             want.lower_limit, got.lower_limit,
                             want.queried_index, got.queried_index);
                end
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COUNT_W-1:0]   cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [REQ_W-1:0]     req_type;
    logic [SLOT_W-1:0]    point_slot;
    logic [FIELD_X_W-1:0] point_x;
    logic [Y_W-1:0]       point_y;
    logic [FIELD_X_W-1:0] sample_index;
    logic                 out_valid;
    logic                 out_ready;
    logic [Y_W-1:0]       upper_limit;
    logic [Y_W-1:0]       lower_limit;
    logic [FIELD_X_W-1:0] queried_index;

    limit_scoreboard sb = new();
    bit              quiet;
    bit              hold_req;

    piecewise_linear_limit_mask_top u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_req_type      (req_type),
        .i_point_slot    (point_slot),
        .i_point_x       (point_x),
        .i_point_y       (point_y),
        .i_sample_index  (sample_index),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_upper_limit   (upper_limit),
        .o_lower_limit   (lower_limit),
        .o_queried_index (queried_index)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    initial begin
        int hold_left;
        bit hold_prev;
        hold_left = 0;
        hold_prev = 1'b0;
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req && !hold_prev) begin
                hold_left = HOLD_CYCLES;
            end
            hold_prev = hold_req;
            if (hold_left != 0) begin
                out_ready = 1'b0;
                hold_left--;
            end else begin
                out_ready = quiet || ($urandom_range(0, 99) >= 8);
            end
        end
    end

    always @(posedge clk) begin
        if (out_valid === 1'b1 && out_ready === 1'b1) begin
            sb.check_result('{upper_limit, lower_limit, queried_index});
        end
    end

    task automatic send_item(input logic [REQ_W-1:0] req,
                             input logic [SLOT_W-1:0] slot,
                             input logic [FIELD_X_W-1:0] px,
                             input logic [Y_W-1:0] py,
                             input logic [FIELD_X_W-1:0] si);
        @(negedge clk);
        while (!quiet && $urandom_range(0, 99) < 8) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        req_type     = req;
        point_slot   = slot;
        point_x      = px;
        point_y      = py;
        sample_index = si;
        in_valid     = 1'b1;
        do @(posedge clk); while (in_ready !== 1'b1);
        sb.note_request(req, slot, px, py, si);
    endtask

    task automatic send_point(input bit upper_line, input int slot, input int x,
                              input int y);
        send_item(upper_line ? REQ_UPPER : REQ_LOWER, SLOT_W'(slot), FIELD_X_W'(x),
                  Y_W'(y), FIELD_X_W'($urandom_range(0, X_TOP)));
    endtask

    task automatic send_query(input int si);
        send_item(REQ_QUERY, SLOT_W'($urandom_range(0, 15)),
                  FIELD_X_W'($urandom_range(0, X_TOP)),
                  Y_W'($urandom_range(0, Y_TOP)), FIELD_X_W'(si));
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (LATENCY_MAX) @(posedge clk);
    endtask

    task automatic write_counts(input int upper_count, input int lower_count);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = CFG_UPPER_COUNT;
        cfg_data  = COUNT_W'(upper_count);
        @(posedge clk);
        sb.set_count(CFG_UPPER_COUNT, COUNT_W'(upper_count));
        @(negedge clk);
        cfg_index = CFG_LOWER_COUNT;
        cfg_data  = COUNT_W'(lower_count);
        @(posedge clk);
        sb.set_count(CFG_LOWER_COUNT, COUNT_W'(lower_count));
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic int pick_y();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return Y_TOP;
            default: return $urandom_range(0, Y_TOP);
        endcase
    endfunction

    function automatic int pick_sample();
        int mode;
        bit upper_line;
        int n;
        int k;
        int s;
        int x_lo;
        int x_hi;
        mode       = $urandom_range(0, 99);
        upper_line = $urandom_range(0, 1);
        n          = upper_line ? sb.up_count : sb.lo_count;
        if (n > MAX_PTS) begin
            n = MAX_PTS;
        end
        if (n == 0 || mode >= 80) begin
            case ($urandom_range(0, 3))
                0: return 0;
                1: return X_TOP;
                default: return $urandom_range(0, X_TOP);
            endcase
        end
        if (mode < 35) begin
            k = $urandom_range(0, n - 1);
            s = upper_line ? sb.up_x[k] : sb.lo_x[k];
            if ($urandom_range(0, 3) == 0) begin
                s = (s + 1) % (X_TOP + 1);
            end
            return s;
        end
        x_lo = upper_line ? sb.up_x[0] : sb.lo_x[0];
        x_hi = upper_line ? sb.up_x[n-1] : sb.lo_x[n-1];
        return $urandom_range(x_lo, x_hi);
    endfunction

    // Rewrites every slot of one table with points rising in x, now and then
    // repeating an x so that vertical steps occur.
    task automatic reload_table(input bit upper_line);
        int x;
        int step_max;
        x = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 2000);
        case ($urandom_range(0, 2))
            0: step_max = 40;
            1: step_max = 400;
            default: step_max = 1200;
        endcase
        for (int k = 0; k < MAX_PTS; k++) begin
            if (k != 0 && $urandom_range(0, 7) != 0) begin
                x += $urandom_range(1, step_max);
            end
            if (x > X_TOP) begin
                x = X_TOP;
            end
            send_point(upper_line, k, x, pick_y());
        end
    endtask

    initial begin
        int up_cnt;
        int lo_cnt;
        int done_items;
        int kind;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        req_type     = '0;
        point_slot   = '0;
        point_x      = '0;
        point_y      = '0;
        sample_index = '0;
        quiet        = 1'b0;
        hold_req     = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Empty tables, an unused request code, then two short tables with
        // a shared x in each.
        send_query(0);
        send_query(X_TOP);
        send_item(REQ_UNUSED, '1, '1, Y_W'(Y_TOP), '1);
        send_point(1'b1, 0, 0, Y_TOP);
        send_point(1'b1, 1, 100, 1000);
        send_point(1'b1, 2, 100, 3000);
        send_point(1'b1, 3, X_TOP, 0);
        send_point(1'b0, 0, 10, 0);
        send_point(1'b0, 1, 100, 200);
        send_point(1'b0, 2, 100, 50);
        send_point(1'b0, 3, 8000, Y_TOP);
        send_point(1'b1, 15, X_TOP, Y_TOP);
        settle();
        write_counts(4, 4);
        send_query(0);
        send_query(5);
        send_query(50);
        send_query(100);
        send_query(101);
        send_query(4000);
        send_query(8000);
        send_query(9000);
        send_query(X_TOP);

        for (int phase = 0; phase < 8; phase++) begin
            settle();
            quiet    = (phase == 3);
            hold_req = (phase == 2);
            case (phase)
                0: begin up_cnt = 16; lo_cnt = 16; end
                1: begin up_cnt = 31; lo_cnt = 31; end
                2: begin up_cnt = 0;  lo_cnt = 16; end
                3: begin up_cnt = 16; lo_cnt = 0;  end
                4: begin up_cnt = 1;  lo_cnt = 2;  end
                5: begin up_cnt = 2;  lo_cnt = 17; end
                default: begin
                    up_cnt = $urandom_range(0, 31);
                    lo_cnt = $urandom_range(0, 31);
                end
            endcase
            write_counts(up_cnt, lo_cnt);
            if (phase == 0) begin
                reload_table(1'b1);
                reload_table(1'b0);
            end
            done_items = 0;
            while (done_items < 40) begin
                kind = $urandom_range(0, 99);
                if (kind < 5) begin
                    reload_table(kind[0]);
                    done_items += MAX_PTS;
                end else if (kind < 12) begin
                    send_point(kind[0], $urandom_range(0, 15), $urandom_range(0, X_TOP),
                               pick_y());
                    done_items++;
                end else if (kind < 16) begin
                    send_item(REQ_UNUSED, SLOT_W'($urandom_range(0, 15)),
                              FIELD_X_W'($urandom_range(0, X_TOP)), Y_W'(pick_y()),
                              FIELD_X_W'($urandom_range(0, X_TOP)));
                end else begin
                    send_query(pick_sample());
                    done_items++;
                end
            end
        end
        settle();

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
